FILE: rtl/core/sm4_pkg.sv
// SM4 package: payload types, S-box, FK and CK constants, round functions.
`timescale 1ns / 1ps
`default_nettype none
package sm4_pkg;

  localparam int unsigned NumRounds = 32;

  typedef enum logic [1:0] {
    CfgKeyHigh = 2'd0,
    CfgKeyLow  = 2'd1
  } cfg_idx_e;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  typedef struct packed {
    logic        command;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } sm4_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } sm4_out_t;

  localparam logic [31:0] Fk0 = 32'hA3B1BAC6;
  localparam logic [31:0] Fk1 = 32'h56AA3350;
  localparam logic [31:0] Fk2 = 32'h677D9197;
  localparam logic [31:0] Fk3 = 32'hB27022DC;

  localparam logic [7:0] Sbox [256] = '{
    8'hD6,8'h90,8'hE9,8'hFE,8'hCC,8'hE1,8'h3D,8'hB7,8'h16,8'hB6,8'h14,8'hC2,8'h28,8'hFB,8'h2C,8'h05,
    8'h2B,8'h67,8'h9A,8'h76,8'h2A,8'hBE,8'h04,8'hC3,8'hAA,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9C,8'h42,8'h50,8'hF4,8'h91,8'hEF,8'h98,8'h7A,8'h33,8'h54,8'h0B,8'h43,8'hED,8'hCF,8'hAC,8'h62,
    8'hE4,8'hB3,8'h1C,8'hA9,8'hC9,8'h08,8'hE8,8'h95,8'h80,8'hDF,8'h94,8'hFA,8'h75,8'h8F,8'h3F,8'hA6,
    8'h47,8'h07,8'hA7,8'hFC,8'hF3,8'h73,8'h17,8'hBA,8'h83,8'h59,8'h3C,8'h19,8'hE6,8'h85,8'h4F,8'hA8,
    8'h68,8'h6B,8'h81,8'hB2,8'h71,8'h64,8'hDA,8'h8B,8'hF8,8'hEB,8'h0F,8'h4B,8'h70,8'h56,8'h9D,8'h35,
    8'h1E,8'h24,8'h0E,8'h5E,8'h63,8'h58,8'hD1,8'hA2,8'h25,8'h22,8'h7C,8'h3B,8'h01,8'h21,8'h78,8'h87,
    8'hD4,8'h00,8'h46,8'h57,8'h9F,8'hD3,8'h27,8'h52,8'h4C,8'h36,8'h02,8'hE7,8'hA0,8'hC4,8'hC8,8'h9E,
    8'hEA,8'hBF,8'h8A,8'hD2,8'h40,8'hC7,8'h38,8'hB5,8'hA3,8'hF7,8'hF2,8'hCE,8'hF9,8'h61,8'h15,8'hA1,
    8'hE0,8'hAE,8'h5D,8'hA4,8'h9B,8'h34,8'h1A,8'h55,8'hAD,8'h93,8'h32,8'h30,8'hF5,8'h8C,8'hB1,8'hE3,
    8'h1D,8'hF6,8'hE2,8'h2E,8'h82,8'h66,8'hCA,8'h60,8'hC0,8'h29,8'h23,8'hAB,8'h0D,8'h53,8'h4E,8'h6F,
    8'hD5,8'hDB,8'h37,8'h45,8'hDE,8'hFD,8'h8E,8'h2F,8'h03,8'hFF,8'h6A,8'h72,8'h6D,8'h6C,8'h5B,8'h51,
    8'h8D,8'h1B,8'hAF,8'h92,8'hBB,8'hDD,8'hBC,8'h7F,8'h11,8'hD9,8'h5C,8'h41,8'h1F,8'h10,8'h5A,8'hD8,
    8'h0A,8'hC1,8'h31,8'h88,8'hA5,8'hCD,8'h7B,8'hBD,8'h2D,8'h74,8'hD0,8'h12,8'hB8,8'hE5,8'hB4,8'hB0,
    8'h89,8'h69,8'h97,8'h4A,8'h0C,8'h96,8'h77,8'h7E,8'h65,8'hB9,8'hF1,8'h09,8'hC5,8'h6E,8'hC6,8'h84,
    8'h18,8'hF0,8'h7D,8'hEC,8'h3A,8'hDC,8'h4D,8'h20,8'h79,8'hEE,8'h5F,8'h3E,8'hD7,8'hCB,8'h39,8'h48
  };

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {Sbox[x[31:24]], Sbox[x[23:16]], Sbox[x[15:8]], Sbox[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] t_data(input logic [31:0] x);
    logic [31:0] b;
    b = sub_word(x);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] t_key(input logic [31:0] x);
    logic [31:0] b;
    b = sub_word(x);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // CK byte j of round i is (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input int unsigned i);
    logic [31:0] w;
    w = '0;
    for (int unsigned j = 0; j < 4; j++) begin
      w = {w[23:0], 8'(((4 * i) + j) * 7)};
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sm4_block_cipher_unit.sv
// SM4 block cipher: key expansion on write, 32-stage round pipeline.
// One round per stage; the result is held in the output register of the last stage.
// Throughput: one item per cycle; a stall freezes the whole pipeline.
// Round keys are expanded serially after reset and after a key write, one round of the
// key loop per cycle; the input stalls until the expansion ends. Configure only while idle.
// Reset: asynchronous, active low; clears valid bits and the key to zero.
`timescale 1ns / 1ps
`default_nettype none
module sm4_block_cipher_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  sm4_pkg::sm4_in_t     in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output sm4_pkg::sm4_out_t    out_data_o,
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  [1:0]           cfg_index_i,
  input  wire  [63:0]          cfg_data_i
);
  import sm4_pkg::*;

  localparam int unsigned CntW = $clog2(NumRounds + 1);

  logic [63:0] key_high_q, key_low_q;
  logic [31:0] rk_q [NumRounds];
  logic [127:0] kw_q;
  logic [CntW-1:0] kcnt_q;
  logic kbusy_q, kstart_q;

  logic        v_q   [NumRounds+1];
  logic        dec_q [NumRounds];
  logic [127:0] x_q  [NumRounds+1];
  logic [31:0] nx_w  [NumRounds];
  logic        adv;
  logic        key_wait;

  assign cfg_ready_o = 1'b1;

  // key registers and serial round-key expansion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      kstart_q   <= 1'b1;
      kbusy_q    <= 1'b0;
      kcnt_q     <= '0;
    end else begin
      kstart_q <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgKeyHigh: begin key_high_q <= cfg_data_i; kstart_q <= 1'b1; end
          CfgKeyLow:  begin key_low_q  <= cfg_data_i; kstart_q <= 1'b1; end
          default: ;
        endcase
      end
      if (kstart_q) begin
        kbusy_q <= 1'b1;
        kcnt_q  <= '0;
      end else if (kbusy_q) begin
        if (kcnt_q == CntW'(NumRounds - 1)) kbusy_q <= 1'b0;
        kcnt_q <= kcnt_q + 1'b1;
      end
    end
  end

  logic [31:0] nk;
  logic [31:0] ck_sel;
  always_comb begin
    ck_sel = '0;
    for (int unsigned i = 0; i < NumRounds; i++) begin
      if (kcnt_q == CntW'(i)) ck_sel = ck_word(i);
    end
    nk = kw_q[127:96] ^ t_key(kw_q[95:64] ^ kw_q[63:32] ^ kw_q[31:0] ^ ck_sel);
  end

  always_ff @(posedge clk_i) begin
    if (kstart_q) begin
      kw_q <= {key_high_q[63:32] ^ Fk0, key_high_q[31:0] ^ Fk1,
               key_low_q[63:32] ^ Fk2, key_low_q[31:0] ^ Fk3};
    end else if (kbusy_q) begin
      kw_q <= {kw_q[95:0], nk};
      rk_q[kcnt_q[CntW-2:0]] <= nk;
    end
  end

  // round pipeline: stage 0 is the input register, stage NumRounds the output
  assign key_wait    = kstart_q | kbusy_q;
  assign adv         = !(v_q[NumRounds] && out_stall_i);
  assign in_stall_o  = !adv || key_wait;
  assign out_valid_o = v_q[NumRounds];
  assign out_data_o  = sm4_out_t'({x_q[NumRounds][31:0], x_q[NumRounds][63:32],
                                   x_q[NumRounds][95:64], x_q[NumRounds][127:96]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NumRounds; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i && !key_wait;
      for (int i = 1; i <= NumRounds; i++) v_q[i] <= v_q[i-1];
    end
  end

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    logic [31:0] rkey;
    assign rkey    = (dec_q[r] == CmdDecrypt) ? rk_q[NumRounds-1-r] : rk_q[r];
    assign nx_w[r] = x_q[r][127:96] ^
                     t_data(x_q[r][95:64] ^ x_q[r][63:32] ^ x_q[r][31:0] ^ rkey);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0]   <= {in_data_i.block_high, in_data_i.block_low};
      dec_q[0] <= in_data_i.command;
      for (int i = 0; i < NumRounds; i++) x_q[i+1] <= {x_q[i][95:0], nx_w[i]};
      for (int i = 1; i < NumRounds; i++) dec_q[i] <= dec_q[i-1];
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/sm4_block_cipher_checker.sv
// Checker for the SM4 unit: predicts each block result and compares it on the output side.
`timescale 1ns / 1ps
module sm4_block_cipher_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  sm4_pkg::sm4_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  sm4_pkg::sm4_out_t out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  import sm4_pkg::*;

  logic [63:0] key_hi_q, key_lo_q;
  sm4_out_t    expected_blocks[$];

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] sbox_word(logic [31:0] x);
    return {Sbox[x[31:24]], Sbox[x[23:16]], Sbox[x[15:8]], Sbox[x[7:0]]};
  endfunction

  function automatic sm4_out_t cipher_block(sm4_in_t item, logic [63:0] khi, logic [63:0] klo);
    logic [31:0] kw[4];
    logic [31:0] xw[4];
    logic [31:0] rkeys[32];
    logic [31:0] b, nw, ck, rk;
    kw[0] = khi[63:32] ^ Fk0;
    kw[1] = khi[31:0]  ^ Fk1;
    kw[2] = klo[63:32] ^ Fk2;
    kw[3] = klo[31:0]  ^ Fk3;
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * i + j) * 7)};
      b = sbox_word(kw[1] ^ kw[2] ^ kw[3] ^ ck);
      nw = kw[0] ^ b ^ rol32(b, 13) ^ rol32(b, 23);
      kw[0] = kw[1]; kw[1] = kw[2]; kw[2] = kw[3]; kw[3] = nw;
      rkeys[i] = nw;
    end
    xw[0] = item.block_high[63:32];
    xw[1] = item.block_high[31:0];
    xw[2] = item.block_low[63:32];
    xw[3] = item.block_low[31:0];
    for (int i = 0; i < 32; i++) begin
      // decrypt walks the key schedule backwards
      rk = (item.command == CmdDecrypt) ? rkeys[31 - i] : rkeys[i];
      b = sbox_word(xw[1] ^ xw[2] ^ xw[3] ^ rk);
      nw = xw[0] ^ b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
      xw[0] = xw[1]; xw[1] = xw[2]; xw[2] = xw[3]; xw[3] = nw;
    end
    return '{result_high: {xw[3], xw[2]}, result_low: {xw[1], xw[0]}};
  endfunction

  assign pending_o = expected_blocks.size();

  always @(posedge clk_i or negedge rst_ni) begin
    sm4_out_t exp_blk;
    int errs;
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
      fail_count_o <= 0;
      checked_o <= 0;
      expected_blocks.delete();
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgKeyHigh) key_hi_q <= cfg_data_i;
        else if (cfg_index_i == CfgKeyLow) key_lo_q <= cfg_data_i;
      end
      if (in_valid_i && !in_stall_i)
        expected_blocks.push_back(cipher_block(in_data_i, key_hi_q, key_lo_q));
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
          errs++;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (out_data_i.result_high !== exp_blk.result_high) begin
            $display("%0t: result_high mismatch, expected %h, actual %h", $time,
                     exp_blk.result_high, out_data_i.result_high);
            errs++;
          end
          if (out_data_i.result_low !== exp_blk.result_low) begin
            $display("%0t: result_low mismatch, expected %h, actual %h", $time,
                     exp_blk.result_low, out_data_i.result_low);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

FILE: tb/sv/sm4_block_cipher_unit_tb.sv
// Testbench top for the SM4 unit: stimulus, output stalls, key phases and verdict.
`timescale 1ns / 1ps
module sm4_block_cipher_unit_tb;
  import sm4_pkg::*;

  localparam logic [1:0] CfgSpare2 = 2'd2;
  localparam logic [1:0] CfgSpare3 = 2'd3;
  localparam int unsigned DrainCycles = 48;

  logic        clk, rst_n;
  logic        in_valid, in_stall, out_valid, out_stall;
  sm4_in_t     in_data;
  sm4_out_t    out_data;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        quiet;
  int          fail_count, pending, checked, items_sent, key_phases;

  sm4_block_cipher_unit u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  sm4_block_cipher_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // receiver backpressure
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  // stall is sampled mid-cycle, where it holds the value seen at the next edge
  task automatic send_block(logic cmd, logic [63:0] hi, logic [63:0] lo);
    logic taken;
    in_valid <= 1'b1;
    in_data <= '{command: cmd, block_high: hi, block_low: lo};
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic idle_cycle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // key writes happen only with the pipeline drained
  task automatic write_reg(logic [1:0] idx, logic [63:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_key(logic [63:0] hi, logic [63:0] lo);
    write_reg(CfgKeyHigh, hi);
    write_reg(CfgKeyLow, lo);
    key_phases++;
  endtask

  task automatic random_run(int count);
    for (int n = 0; n < count; n++) begin
      quiet = (n >= count / 3) && (n < count / 3 + 40);
      if (!quiet && $urandom_range(99) < 17) idle_cycle();
      send_block(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CfgKeyHigh;
    cfg_data = '0;
    quiet = 1'b0;
    items_sent = 0;
    key_phases = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, zero key after reset
    send_block(CmdEncrypt, '0, '0);
    send_block(CmdDecrypt, '0, '0);
    send_block(CmdEncrypt, '1, '1);
    send_block(CmdDecrypt, '1, '1);
    send_block(CmdEncrypt, 64'hAAAAAAAA55555555, 64'h55555555AAAAAAAA);
    send_block(CmdDecrypt, 64'h8000000000000000, 64'h0000000000000001);

    // standard key, known vector and its inverse
    load_key(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    send_block(CmdEncrypt, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    send_block(CmdDecrypt, 64'h681EDF34D206965E, 64'h86B3E94F536E4246);
    send_block(CmdEncrypt, '0, '1);
    send_block(CmdDecrypt, '1, '0);

    // writes to unmapped indexes must leave the key alone
    write_reg(CfgSpare2, '1);
    write_reg(CfgSpare3, 64'hDEADBEEFCAFEF00D);
    send_block(CmdEncrypt, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);

    load_key('1, '1);
    send_block(CmdEncrypt, '0, '0);
    send_block(CmdDecrypt, '1, '1);
    send_block(CmdEncrypt, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
    random_run(120);

    load_key('0, '1);
    random_run(120);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    random_run(200);
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    random_run(190);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    $display("Covered %0d blocks (%0d checked) over %0d keys, both directions,",
             items_sent, checked, key_phases + 1);
    $display("with random input gaps and output stalls.");
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
